// File: rtl/swk_pkg.sv
// ----------------------------------------------------------------------------
// swk_pkg
// Shared types and constants for the swerve wheel kinematics core.
// ----------------------------------------------------------------------------
package swk_pkg;

    typedef enum logic [2:0] {
        CASE_BACK       = 3'd0,
        CASE_BACK_RIGHT = 3'd1,
        CASE_BACK_LEFT  = 3'd2,
        CASE_RIGHT_SPIN = 3'd3,
        CASE_LEFT_SPIN  = 3'd4,
        CASE_FORWARD    = 3'd5
    } case_code_t;

    typedef struct packed {
        logic back;
        logic spin_r;
        logic spin_l;
        logic zero;
    } swk_flags_t;

    localparam int ZW = 34;
    localparam logic signed [ZW-1:0] HALF_TURN = 34'sd2147483648;
    localparam logic signed [ZW-1:0] REV_LIMIT = 34'sd1097602753;
    localparam logic signed [22:0] COUNTS_PER_TURN = 23'sd1145678;
    localparam logic [14:0] SPEED_MAX = 15'd16383;

    localparam logic [31:0] STEP_ANGLE [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
        32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
        32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
    };

endpackage

// File: rtl/swerve_wheel_kinematics_core.sv
// ----------------------------------------------------------------------------
// swerve_wheel_kinematics_core
// Inverse kinematics of one swerve wheel: drive speed and steering target.
// ----------------------------------------------------------------------------
// The core accepts one item of stick values in every cycle while s_tready is
// high, and returns one result item per input item, in order. Items pass the
// wheel vector and prerotation stages, then the pipelined CORDIC lane and the
// bit-per-stage square root lane that run side by side, then the final stages.
// A two-entry output stage keeps the pipeline moving while a result waits.
module swerve_wheel_kinematics_core #(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 20
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [30:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // vel_x [10:0], vel_y [21:11], vel_spin [32:22]
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // drive_rpm [14:0], steer_target [46:15]
    output logic [47:0] m_tdata,
    // case_code [2:0]
    output logic [2:0]  m_tuser
);

    localparam int AW   = FRAC_BITS + 13;
    localparam int CW   = AW + 2;
    localparam int ZW   = swk_pkg::ZW;
    localparam int M    = (FRAC_BITS > 16) ? 16 : FRAC_BITS;
    localparam int DROP = FRAC_BITS - M;
    localparam int UW   = 11 + M;
    localparam int RW   = UW + 1;
    localparam int SW   = 2 * UW + 2;
    localparam int L    = (CORDIC_STEPS > RW) ? CORDIC_STEPS : RW;
    localparam longint C45_L = ((longint'(707106) << FRAC_BITS) + 500000) / 1000000;
    localparam logic signed [AW-1:0] C45 = AW'(C45_L);

    logic signed [30:0] steer_ref_reg;
    logic en;
    logic accept;

    logic signed [10:0] vx, vy, vw;
    assign vx = s_tdata[10:0];
    assign vy = s_tdata[21:11];
    assign vw = s_tdata[32:22];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steer_ref_reg <= '0;
        end
        else if (cfg_we)
        begin
            steer_ref_reg <= cfg_wdata;
        end
    end

    // Stage 1: wheel vector.
    logic v1_reg;
    logic signed [AW-1:0] a1_reg, b1_reg;
    swk_pkg::swk_flags_t f1_reg;
    logic signed [AW-1:0] a1_next, b1_next;
    swk_pkg::swk_flags_t f1_next;

    always_comb
    begin
        a1_next = (AW'(vx) <<< FRAC_BITS) + AW'(vw) * C45;
        b1_next = (AW'(vy) <<< FRAC_BITS) - AW'(vw) * C45;
        f1_next.back   = (vy < 0) && (vx <= 11'sd2) && (vx >= -11'sd2) && (vw == 0);
        f1_next.spin_r = (vw > 0) && (vx == 0) && (vy == 0);
        f1_next.spin_l = (vw < 0) && (vx == 0) && (vy == 0);
        f1_next.zero   = (a1_next == 0) && (b1_next == 0);
    end

    // Stage 2: half-turn prerotation and truncated magnitudes.
    logic v2_reg;
    logic signed [CW-1:0] x2_reg, y2_reg;
    logic signed [ZW-1:0] z2_reg;
    logic [UW-1:0] ua2_reg, ub2_reg;
    swk_pkg::swk_flags_t f2_reg;
    logic [AW-1:0] abs_a, abs_b;
    logic [AW-1:0] shr_a, shr_b;

    always_comb
    begin
        abs_a = a1_reg[AW-1] ? AW'(-a1_reg) : AW'(a1_reg);
        abs_b = b1_reg[AW-1] ? AW'(-b1_reg) : AW'(b1_reg);
        shr_a = abs_a >> DROP;
        shr_b = abs_b >> DROP;
    end

    // Lanes: CORDIC and square root side by side.
    logic                 vl_reg [L+1];
    logic signed [CW-1:0] cx_reg [L+1];
    logic signed [CW-1:0] cy_reg [L+1];
    logic signed [ZW-1:0] cz_reg [L+1];
    logic [SW-1:0]        sr_reg [L+1];
    logic [RW-1:0]        sq_reg [L+1];
    swk_pkg::swk_flags_t  fl_reg [L+1];

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            vl_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v1_reg    <= accept;
            v2_reg    <= v1_reg;
            vl_reg[0] <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg <= a1_next;
            b1_reg <= b1_next;
            f1_reg <= f1_next;
            if (b1_reg[AW-1])
            begin
                x2_reg <= -CW'(b1_reg);
                y2_reg <= -CW'(a1_reg);
                z2_reg <= a1_reg[AW-1] ? -swk_pkg::HALF_TURN : swk_pkg::HALF_TURN;
            end
            else
            begin
                x2_reg <= CW'(b1_reg);
                y2_reg <= CW'(a1_reg);
                z2_reg <= '0;
            end
            ua2_reg <= shr_a[UW-1:0];
            ub2_reg <= shr_b[UW-1:0];
            f2_reg  <= f1_reg;
            cx_reg[0] <= x2_reg;
            cy_reg[0] <= y2_reg;
            cz_reg[0] <= z2_reg;
            sr_reg[0] <= SW'(ua2_reg) * SW'(ua2_reg) + SW'(ub2_reg) * SW'(ub2_reg);
            sq_reg[0] <= '0;
            fl_reg[0] <= f2_reg;
        end
    end

    for (genvar j = 0; j < L; j++)
    begin : g_lane
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vl_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                vl_reg[j+1] <= vl_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                fl_reg[j+1] <= fl_reg[j];
            end
        end

        if (j < CORDIC_STEPS)
        begin : g_cordic
            localparam logic signed [ZW-1:0] ANG = ZW'(swk_pkg::STEP_ANGLE[j]);
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (cy_reg[j] > 0)
                    begin
                        cx_reg[j+1] <= cx_reg[j] + (cy_reg[j] >>> j);
                        cy_reg[j+1] <= cy_reg[j] - (cx_reg[j] >>> j);
                        cz_reg[j+1] <= cz_reg[j] + ANG;
                    end
                    else
                    begin
                        cx_reg[j+1] <= cx_reg[j] - (cy_reg[j] >>> j);
                        cy_reg[j+1] <= cy_reg[j] + (cx_reg[j] >>> j);
                        cz_reg[j+1] <= cz_reg[j] - ANG;
                    end
                end
            end
        end
        else
        begin : g_chold
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    cx_reg[j+1] <= cx_reg[j];
                    cy_reg[j+1] <= cy_reg[j];
                    cz_reg[j+1] <= cz_reg[j];
                end
            end
        end

        if (j < RW)
        begin : g_sqrt
            localparam int K = RW - 1 - j;
            logic [SW:0] trial;
            assign trial = ((SW + 1)'(sq_reg[j]) << (K + 1)) + ((SW + 1)'(1) << (2 * K));
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if ((SW + 1)'(sr_reg[j]) >= trial)
                    begin
                        sr_reg[j+1] <= SW'((SW + 1)'(sr_reg[j]) - trial);
                        sq_reg[j+1] <= sq_reg[j] | (RW'(1) << K);
                    end
                    else
                    begin
                        sr_reg[j+1] <= sr_reg[j];
                        sq_reg[j+1] <= sq_reg[j];
                    end
                end
            end
        end
        else
        begin : g_shold
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    sr_reg[j+1] <= sr_reg[j];
                    sq_reg[j+1] <= sq_reg[j];
                end
            end
        end
    end

    // Final stages: case decision, count scaling, truncation and saturation.
    logic vf1_reg, vf2_reg, vf3_reg, vf4_reg;
    logic signed [ZW-1:0] h_reg;
    logic signed [14:0] rpm1_reg, rpm2_reg, rpm3_reg, rpm4_reg;
    swk_pkg::case_code_t code1_reg, code2_reg, code3_reg, code4_reg;
    logic signed [ZW+22:0] prod_reg;
    logic signed [65:0] sum_reg;
    logic signed [31:0] tgt_reg;

    logic signed [ZW-1:0] t_head, h_next;
    swk_pkg::case_code_t code_next;
    logic reverse;
    logic [RW-1:0] sp_raw;
    logic [14:0] sp;
    logic signed [14:0] rpm_next;
    logic [65:0] sum_mag;
    logic signed [34:0] q_tr;
    logic signed [31:0] tgt_next;

    always_comb
    begin
        t_head = fl_reg[L].zero ? '0 : cz_reg[L];
        if (fl_reg[L].back)
        begin
            code_next = swk_pkg::CASE_BACK;
            reverse   = 1'b1;
            h_next    = '0;
        end
        else if (t_head > swk_pkg::REV_LIMIT)
        begin
            code_next = swk_pkg::CASE_BACK_RIGHT;
            reverse   = 1'b1;
            h_next    = swk_pkg::HALF_TURN - t_head;
        end
        else if (-t_head > swk_pkg::REV_LIMIT)
        begin
            code_next = swk_pkg::CASE_BACK_LEFT;
            reverse   = 1'b1;
            h_next    = -swk_pkg::HALF_TURN - t_head;
        end
        else if (fl_reg[L].spin_r)
        begin
            code_next = swk_pkg::CASE_RIGHT_SPIN;
            reverse   = 1'b1;
            h_next    = swk_pkg::HALF_TURN - t_head;
        end
        else if (fl_reg[L].spin_l)
        begin
            code_next = swk_pkg::CASE_LEFT_SPIN;
            reverse   = 1'b0;
            h_next    = -t_head;
        end
        else
        begin
            code_next = swk_pkg::CASE_FORWARD;
            reverse   = 1'b0;
            h_next    = -t_head;
        end
        sp_raw = sq_reg[L] >> (M - 3);
        sp = (sp_raw > RW'(swk_pkg::SPEED_MAX)) ? swk_pkg::SPEED_MAX : sp_raw[14:0];
        rpm_next = reverse ? -$signed(sp) : $signed(sp);

        sum_mag = sum_reg[65] ? 66'(-sum_reg) : 66'(sum_reg);
        q_tr = sum_reg[65] ? -$signed({1'b0, sum_mag[65:32]}) : $signed({1'b0, sum_mag[65:32]});
        if (q_tr > 35'sd2147483647)
        begin
            tgt_next = 32'sh7FFFFFFF;
        end
        else if (q_tr < -35'sd2147483648)
        begin
            tgt_next = 32'sh80000000;
        end
        else
        begin
            tgt_next = q_tr[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vf1_reg <= 1'b0;
            vf2_reg <= 1'b0;
            vf3_reg <= 1'b0;
            vf4_reg <= 1'b0;
        end
        else if (en)
        begin
            vf1_reg <= vl_reg[L];
            vf2_reg <= vf1_reg;
            vf3_reg <= vf2_reg;
            vf4_reg <= vf3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_reg     <= h_next;
            rpm1_reg  <= rpm_next;
            code1_reg <= code_next;
            prod_reg  <= (ZW + 23)'(h_reg) * (ZW + 23)'(swk_pkg::COUNTS_PER_TURN);
            rpm2_reg  <= rpm1_reg;
            code2_reg <= code1_reg;
            sum_reg   <= 66'(prod_reg) + (66'(steer_ref_reg) <<< 32);
            rpm3_reg  <= rpm2_reg;
            code3_reg <= code2_reg;
            tgt_reg   <= tgt_next;
            rpm4_reg  <= rpm3_reg;
            code4_reg <= code3_reg;
        end
    end

    // Output register with a skid entry behind it.
    logic out_v_reg, skid_v_reg;
    logic [49:0] out_reg, skid_reg;
    logic [49:0] last_item;
    logic last_v;

    assign last_item = {code4_reg, tgt_reg, rpm4_reg};
    assign last_v    = vf4_reg && en;
    assign en        = !skid_v_reg;
    assign s_tready  = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (!out_v_reg || m_tready)
        begin
            out_v_reg  <= skid_v_reg || last_v;
            skid_v_reg <= 1'b0;
        end
        else if (last_v)
        begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_v_reg || m_tready)
        begin
            out_reg <= skid_v_reg ? skid_reg : last_item;
        end
        else if (last_v)
        begin
            skid_reg <= last_item;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {1'b0, out_reg[46:0]};
    assign m_tuser  = out_reg[49:47];

    a_skid_needs_out : assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> out_v_reg)
        else $error("skid entry held while output register empty");

    a_stall_only_full : assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (skid_v_reg && out_v_reg))
        else $error("input stalled without a full output stage");

    a_no_right_spin : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser != swk_pkg::CASE_RIGHT_SPIN))
        else $error("unreachable right spin case reported");

    a_reverse_sign : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == swk_pkg::CASE_BACK || m_tuser == swk_pkg::CASE_BACK_LEFT
            || m_tuser == swk_pkg::CASE_BACK_RIGHT)) |-> (m_tdata[14] || m_tdata[14:0] == 15'd0))
        else $error("reversed case with positive drive speed");

endmodule
